[hw/rtl/yuvs_pkg.sv]
// ============================================================================
// yuvs_pkg - shared definitions for the YUV420 downscaler with BGRA conversion
// Register indexes, reset values, conversion coefficients, control struct.
// ============================================================================
`default_nettype none

package yuvs_pkg;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd1080;
    localparam logic [CFG_W-1:0] RST_OUT_WIDTH  = 13'd960;
    localparam logic [CFG_W-1:0] RST_OUT_HEIGHT = 13'd540;

    localparam int MAX_DIMENSION_DEF = 4096;

    // pixel widths
    localparam int PIX_W = 8;

    // BT.601 studio range coefficients (8 fractional bits)
    localparam int COEF_Y   = 298;
    localparam int COEF_RV  = 409;
    localparam int COEF_GU  = 100;
    localparam int COEF_GV  = 208;
    localparam int COEF_BU  = 516;
    localparam int ROUND    = 128;
    localparam int Y_OFFSET = 16;

    // per-pixel decision from the position tracker
    typedef struct packed {
        logic pick;
        logic row_end;
        logic frame_end;
    } t_pos_ctrl;

endpackage

`default_nettype wire

[hw/rtl/yuvs_csc.sv]
// ============================================================================
// yuvs_csc - BT.601 studio range YUV to BGR conversion
// Combinational; luma floored at zero, each channel clamped to 0..255.
// ============================================================================
`default_nettype none

module yuvs_csc (
    input  wire logic [yuvs_pkg::PIX_W-1:0] i_luma,
    input  wire logic [yuvs_pkg::PIX_W-1:0] i_chroma_blue,
    input  wire logic [yuvs_pkg::PIX_W-1:0] i_chroma_red,
    output logic      [yuvs_pkg::PIX_W-1:0] o_blue,
    output logic      [yuvs_pkg::PIX_W-1:0] o_green,
    output logic      [yuvs_pkg::PIX_W-1:0] o_red
);

    localparam int S_W = 20;

    logic        [7:0]     luma_c;
    logic signed [9:0]     c_s;
    logic signed [7:0]     u_s;
    logic signed [7:0]     v_s;
    logic signed [S_W-1:0] sum_b;
    logic signed [S_W-1:0] sum_g;
    logic signed [S_W-1:0] sum_r;

    // floor shift by 8 then clamp to 0..255
    function automatic logic [7:0] sat8(input logic signed [S_W-1:0] s);
        logic [7:0] res;
        if (s[S_W-1]) begin
            res = 8'd0;
        end else if (|s[S_W-2:16]) begin
            res = 8'hFF;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    always_comb begin
        luma_c = (i_luma >= 8'(yuvs_pkg::Y_OFFSET)) ? (i_luma - 8'(yuvs_pkg::Y_OFFSET)) : 8'd0;
        c_s    = $signed({2'b00, luma_c});
        // value - 128 as an 8-bit signed number
        u_s    = $signed({~i_chroma_blue[7], i_chroma_blue[6:0]});
        v_s    = $signed({~i_chroma_red[7], i_chroma_red[6:0]});

        sum_b = S_W'(yuvs_pkg::COEF_Y) * S_W'(c_s)
              + S_W'(yuvs_pkg::COEF_BU) * S_W'(u_s)
              + S_W'(yuvs_pkg::ROUND);
        sum_g = S_W'(yuvs_pkg::COEF_Y) * S_W'(c_s)
              - S_W'(yuvs_pkg::COEF_GU) * S_W'(u_s)
              - S_W'(yuvs_pkg::COEF_GV) * S_W'(v_s)
              + S_W'(yuvs_pkg::ROUND);
        sum_r = S_W'(yuvs_pkg::COEF_Y) * S_W'(c_s)
              + S_W'(yuvs_pkg::COEF_RV) * S_W'(v_s)
              + S_W'(yuvs_pkg::ROUND);

        o_blue  = sat8(sum_b);
        o_green = sat8(sum_g);
        o_red   = sat8(sum_r);
    end

endmodule

`default_nettype wire

[hw/rtl/yuvs_pos.sv]
// ============================================================================
// yuvs_pos - source/output position tracker for nearest neighbor downscale
// Add-only accumulators decide which source pixels are kept.
// ============================================================================
`default_nettype none

module yuvs_pos #(
    parameter int MAX_DIMENSION = yuvs_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_advance,
    input  wire logic                                    i_frame_start,
    input  wire logic [$clog2(MAX_DIMENSION+1)-1:0]      i_src_w,
    input  wire logic [$clog2(MAX_DIMENSION+1)-1:0]      i_src_h,
    input  wire logic [$clog2(MAX_DIMENSION+1)-1:0]      i_out_w,
    input  wire logic [$clog2(MAX_DIMENSION+1)-1:0]      i_out_h,
    output yuvs_pkg::t_pos_ctrl                          o_ctrl
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int SUM_W = $clog2(MAX_DIMENSION * MAX_DIMENSION + MAX_DIMENSION + 1);

    logic [DIM_W-1:0] r_src_col, n_src_col, r_src_row, n_src_row;
    logic [DIM_W-1:0] r_out_col, n_out_col, r_out_row, n_out_row;
    logic [SUM_W-1:0] r_col_tgt, n_col_tgt, r_col_base, n_col_base;
    logic [SUM_W-1:0] r_row_tgt, n_row_tgt, r_row_base, n_row_base;

    // state after an optional frame start clear
    logic [DIM_W-1:0] e_src_col, e_src_row, e_out_col, e_out_row;
    logic [SUM_W-1:0] e_col_tgt, e_col_base, e_row_tgt, e_row_base;
    logic             row_pick, col_pick, last_col, last_row;

    always_comb begin
        e_src_col  = i_frame_start ? '0 : r_src_col;
        e_src_row  = i_frame_start ? '0 : r_src_row;
        e_out_col  = i_frame_start ? '0 : r_out_col;
        e_out_row  = i_frame_start ? '0 : r_out_row;
        e_col_tgt  = i_frame_start ? '0 : r_col_tgt;
        e_col_base = i_frame_start ? '0 : r_col_base;
        e_row_tgt  = i_frame_start ? '0 : r_row_tgt;
        e_row_base = i_frame_start ? '0 : r_row_base;

        row_pick = (e_out_row < i_out_h) && (e_row_tgt < e_row_base + SUM_W'(i_out_h));
        col_pick = (e_out_col < i_out_w) && (e_col_tgt < e_col_base + SUM_W'(i_out_w));

        o_ctrl.pick      = row_pick && col_pick;
        o_ctrl.row_end   = ({1'b0, e_out_col} + 1'b1) >= {1'b0, i_out_w};
        o_ctrl.frame_end = o_ctrl.row_end && (({1'b0, e_out_row} + 1'b1) >= {1'b0, i_out_h});

        last_col = ({1'b0, e_src_col} + 1'b1) >= {1'b0, i_src_w};
        last_row = ({1'b0, e_src_row} + 1'b1) >= {1'b0, i_src_h};

        // column pass
        n_col_tgt  = o_ctrl.pick ? e_col_tgt + SUM_W'(i_src_w) : e_col_tgt;
        n_out_col  = o_ctrl.pick ? e_out_col + 1'b1 : e_out_col;
        n_col_base = e_col_base + SUM_W'(i_out_w);
        n_src_col  = e_src_col + 1'b1;
        n_src_row  = e_src_row;
        n_out_row  = e_out_row;
        n_row_tgt  = e_row_tgt;
        n_row_base = e_row_base;

        if (last_col) begin
            n_src_col  = '0;
            n_col_tgt  = '0;
            n_col_base = '0;
            n_out_col  = '0;
            if (last_row) begin
                n_src_row  = '0;
                n_out_row  = '0;
                n_row_tgt  = '0;
                n_row_base = '0;
            end else begin
                n_src_row  = e_src_row + 1'b1;
                n_row_base = e_row_base + SUM_W'(i_out_h);
                if (row_pick) begin
                    n_row_tgt = e_row_tgt + SUM_W'(i_src_h);
                    n_out_row = e_out_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_col_tgt  <= '0;
            r_col_base <= '0;
            r_row_tgt  <= '0;
            r_row_base <= '0;
        end else if (i_advance) begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_col_tgt  <= n_col_tgt;
            r_col_base <= n_col_base;
            r_row_tgt  <= n_row_tgt;
            r_row_base <= n_row_base;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/yuv420_scale_to_bgra_top.sv]
// ============================================================================
// yuv420_scale_to_bgra_top - nearest neighbor downscaler, YUV to BGR output
// Keeps the source pixels picked by the scaler and converts them to BGR.
// ============================================================================
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------------
//  pixel in | i_in_valid / o_in_ready        | i_luma, i_chroma_blue, i_chroma_red,
//           |                                | i_frame_start
//  pixel out| o_out_valid / i_out_ready      | o_blue, o_green, o_red, o_row_end,
//           |                                | o_frame_end
//  config   | i_cfg_we (no wait, no readback)| i_cfg_index, i_cfg_data
//
//  Throughput: one source pixel per clock unless a kept pixel meets a stalled output.
//  After the input transfer a pixel passes the input register, then the result register,
//  which raises o_out_valid and holds the pixel until the output transfer.
//  A dropped pixel leaves the input register even while the output is stalled;
//  a kept pixel waits only for the result register to free up.
//  Reset clears the positions and loads the default sizes; no clearing pass.
//
`default_nettype none

module yuv420_scale_to_bgra_top #(
    parameter int MAX_DIMENSION = yuvs_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // pixel input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [yuvs_pkg::PIX_W-1:0]         i_luma,
    input  wire logic [yuvs_pkg::PIX_W-1:0]         i_chroma_blue,
    input  wire logic [yuvs_pkg::PIX_W-1:0]         i_chroma_red,
    input  wire logic                               i_frame_start,
    // pixel output
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [yuvs_pkg::PIX_W-1:0]         o_blue,
    output logic      [yuvs_pkg::PIX_W-1:0]         o_green,
    output logic      [yuvs_pkg::PIX_W-1:0]         o_red,
    output logic                                    o_row_end,
    output logic                                    o_frame_end,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [yuvs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [yuvs_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = (DIM_W > yuvs_pkg::CFG_W) ? DIM_W : yuvs_pkg::CFG_W;

    // ---------------------------------------------------------------- config
    logic [yuvs_pkg::CFG_W-1:0] r_src_width, r_src_height, r_out_width, r_out_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= yuvs_pkg::RST_SRC_WIDTH;
            r_src_height <= yuvs_pkg::RST_SRC_HEIGHT;
            r_out_width  <= yuvs_pkg::RST_OUT_WIDTH;
            r_out_height <= yuvs_pkg::RST_OUT_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                yuvs_pkg::REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                yuvs_pkg::REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                yuvs_pkg::REG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                yuvs_pkg::REG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero reads as one, source capped at MAX_DIMENSION,
    // output capped at source
    logic [CMP_W-1:0] sw_x, sh_x, ow_x, oh_x;
    logic [DIM_W-1:0] src_w, src_h, out_w, out_h;

    always_comb begin
        sw_x = CMP_W'(r_src_width);
        sh_x = CMP_W'(r_src_height);
        ow_x = CMP_W'(r_out_width);
        oh_x = CMP_W'(r_out_height);

        if (sw_x == '0) sw_x = CMP_W'(1);
        else if (sw_x > CMP_W'(MAX_DIMENSION)) sw_x = CMP_W'(MAX_DIMENSION);
        if (sh_x == '0) sh_x = CMP_W'(1);
        else if (sh_x > CMP_W'(MAX_DIMENSION)) sh_x = CMP_W'(MAX_DIMENSION);
        if (ow_x == '0) ow_x = CMP_W'(1);
        else if (ow_x > sw_x) ow_x = sw_x;
        if (oh_x == '0) oh_x = CMP_W'(1);
        else if (oh_x > sh_x) oh_x = sh_x;

        src_w = DIM_W'(sw_x);
        src_h = DIM_W'(sh_x);
        out_w = DIM_W'(ow_x);
        out_h = DIM_W'(oh_x);
    end

    // ---------------------------------------------------------- input stage
    logic                        r_s1_valid;
    logic [yuvs_pkg::PIX_W-1:0]  r_s1_luma, r_s1_cb, r_s1_cr;
    logic                        r_s1_fs;
    logic                        s1_adv;
    logic                        in_xfer;
    yuvs_pkg::t_pos_ctrl         pos_ctrl;

    // a dropped pixel never needs the result register
    assign s1_adv     = r_s1_valid && (!pos_ctrl.pick || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_luma <= i_luma;
            r_s1_cb   <= i_chroma_blue;
            r_s1_cr   <= i_chroma_red;
            r_s1_fs   <= i_frame_start;
        end
    end

    // ------------------------------------------------- scaler and conversion
    yuvs_pos #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (s1_adv),
        .i_frame_start (r_s1_fs),
        .i_src_w       (src_w),
        .i_src_h       (src_h),
        .i_out_w       (out_w),
        .i_out_h       (out_h),
        .o_ctrl        (pos_ctrl)
    );

    logic [yuvs_pkg::PIX_W-1:0] csc_b, csc_g, csc_r;

    yuvs_csc u_csc (
        .i_luma        (r_s1_luma),
        .i_chroma_blue (r_s1_cb),
        .i_chroma_red  (r_s1_cr),
        .o_blue        (csc_b),
        .o_green       (csc_g),
        .o_red         (csc_r)
    );

    // --------------------------------------------------------- result stage
    logic r_out_valid;
    logic load_out;

    assign load_out    = s1_adv && pos_ctrl.pick;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_blue      <= csc_b;
            o_green     <= csc_g;
            o_red       <= csc_r;
            o_row_end   <= pos_ctrl.row_end;
            o_frame_end <= pos_ctrl.frame_end;
        end
    end

    // ----------------------------------------------------------- assertions
    // last pixel of the frame is also last of its row
    a_frame_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_row_end)
        else $error("frame_end without row_end");

    // a kept pixel never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // a held input item keeps its contents until it advances
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_luma) && $stable(r_s1_fs))
        else $error("input stage lost a stalled pixel");

    // a stalled result holds while no new pixel can load
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(o_blue) && $stable(o_row_end))
        else $error("stalled result changed");

endmodule

`default_nettype wire
